/* src/rbeq_pkg.sv */
// package: shared types and constants for the rotary button event qualifier
package rbeq_pkg;

   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned CountWidth = 16;
   localparam int unsigned CfgWidth   = 16;
   localparam int unsigned CsrIdxWidth  = 3;
   localparam int unsigned CsrDataWidth = 32;

   typedef enum logic [1:0] {
      OP_POLL   = 2'd0,
      OP_PRESET = 2'd1,
      OP_MARK   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ROT_NONE = 2'd0,
      ROT_UP   = 2'd1,
      ROT_DOWN = 2'd2
   } rot_type;

   typedef enum logic [1:0] {
      BTN_NONE  = 2'd0,
      BTN_CLICK = 2'd1,
      BTN_LONG  = 2'd2
   } btn_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_ROTATION_GAP = 3'd0,
      CSR_DEBOUNCE     = 3'd1,
      CSR_LONG_PRESS   = 3'd2,
      CSR_SLEEP        = 3'd3,
      CSR_PRESSED_LVL  = 3'd4
   } csr_idx_type;

   localparam logic [CfgWidth-1:0]  RotationGapReset = 16'd30;
   localparam logic [CfgWidth-1:0]  DebounceReset    = 16'd20;
   localparam logic [CfgWidth-1:0]  LongPressReset   = 16'd1000;
   localparam logic [TimeWidth-1:0] SleepReset       = 32'd60000;
   localparam logic                 PressedLvlReset  = 1'b0;

   typedef struct packed {
      logic [CfgWidth-1:0]  rotation_gap_ms;
      logic [CfgWidth-1:0]  debounce_ms;
      logic [CfgWidth-1:0]  long_press_ms;
      logic [TimeWidth-1:0] sleep_timeout_ms;
      logic                 pressed_level;
   } cfg_type;

   typedef struct packed {
      logic [1:0]                   op;
      logic [TimeWidth-1:0]         time_ms;
      logic                         count_changed;
      logic signed [CountWidth-1:0] knob_count;
      logic                         button_level;
   } item_type;

   typedef struct packed {
      logic signed [CountWidth-1:0] ref_count;
      logic [TimeWidth-1:0]         last_rotation_time;
      logic                         stable_level;
      logic [TimeWidth-1:0]         edge_time;
      logic [TimeWidth-1:0]         press_start;
      logic                         long_done;
      logic [TimeWidth-1:0]         interaction_time;
   } state_type;

   typedef struct packed {
      rot_type rotation_event;
      btn_type button_event;
      logic    idle_expired;
   } result_type;

endpackage

/* src/rbeq_if.sv */
// interfaces: request, response and register write channels

interface rbeq_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        op;
   logic [31:0]       time_ms;
   logic              count_changed;
   logic signed [15:0] knob_count;
   logic              button_level;

   modport source (output valid, op, time_ms, count_changed, knob_count, button_level,
                   input ready);
   modport sink   (input valid, op, time_ms, count_changed, knob_count, button_level,
                   output ready);
endinterface

interface rbeq_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] rotation_event;
   logic [1:0] button_event;
   logic       idle_expired;

   modport source (output valid, rotation_event, button_event, idle_expired, input ready);
   modport sink   (input valid, rotation_event, button_event, idle_expired, output ready);
endinterface

interface rbeq_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* src/rbeq_core.sv */
// next-state and result logic for one item
module rbeq_core (
   input  rbeq_pkg::cfg_type    cfg,
   input  rbeq_pkg::state_type  cur,
   input  rbeq_pkg::item_type   item,
   output rbeq_pkg::state_type  nxt,
   output rbeq_pkg::result_type res
);
   import rbeq_pkg::*;

   logic [TimeWidth-1:0] rot_age;
   logic [TimeWidth-1:0] edge_age;
   logic [TimeWidth-1:0] hold_age;
   logic [TimeWidth-1:0] idle_age;
   logic                 rot_fire;
   logic                 edge_ok;
   logic                 lvl_pressed;
   logic                 click;
   logic                 long_fire;
   logic                 long_done_eff;
   logic [TimeWidth-1:0] hold_eff;
   logic                 touched;

   assign rot_age     = item.time_ms - cur.last_rotation_time;
   assign edge_age    = item.time_ms - cur.edge_time;
   assign hold_age    = item.time_ms - cur.press_start;
   assign idle_age    = item.time_ms - cur.interaction_time;
   assign lvl_pressed = (item.button_level == cfg.pressed_level);

   always_comb begin
      rot_fire      = 1'b0;
      edge_ok       = 1'b0;
      click         = 1'b0;
      long_fire     = 1'b0;
      long_done_eff = cur.long_done;
      hold_eff      = hold_age;
      touched       = 1'b0;
      nxt           = cur;
      res.rotation_event = ROT_NONE;
      res.button_event   = BTN_NONE;

      unique case (item.op)
         OP_POLL: begin
            // knob rotation, rate limited by the gap time
            if (item.count_changed) begin
               rot_fire = (rot_age > {16'd0, cfg.rotation_gap_ms});
               if (rot_fire) begin
                  res.rotation_event     = (item.knob_count > cur.ref_count) ? ROT_UP : ROT_DOWN;
                  nxt.last_rotation_time = item.time_ms;
               end
               nxt.ref_count = item.knob_count;
            end
            // debounced button edge
            edge_ok = (item.button_level != cur.stable_level) &&
                      (edge_age > {16'd0, cfg.debounce_ms});
            if (edge_ok) begin
               nxt.edge_time    = item.time_ms;
               nxt.stable_level = item.button_level;
               if (lvl_pressed) begin
                  nxt.press_start = item.time_ms;
                  nxt.long_done   = 1'b0;
                  long_done_eff   = 1'b0;
                  hold_eff        = '0;
               end else if (!cur.long_done && (hold_age < {16'd0, cfg.long_press_ms})) begin
                  click = 1'b1;
               end
            end
            // long press on the raw level
            long_fire = lvl_pressed && !long_done_eff &&
                        (hold_eff >= {16'd0, cfg.long_press_ms});
            if (long_fire) begin
               nxt.long_done    = 1'b1;
               res.button_event = BTN_LONG;
            end else if (click) begin
               res.button_event = BTN_CLICK;
            end
            touched = rot_fire || click || long_fire;
         end
         OP_PRESET: begin
            nxt.ref_count = item.knob_count;
         end
         OP_MARK: begin
            touched = 1'b1;
         end
         default: begin
         end
      endcase

      if (touched) begin
         nxt.interaction_time = item.time_ms;
      end
      // interaction at this time leaves a zero age
      res.idle_expired = !touched && (idle_age > cfg.sleep_timeout_ms);
   end

endmodule

/* src/rotary_button_event_qualifier_top.sv */
// top level: rotary knob and push button event qualifier
//
// qualifies knob and button polls into rotation, click / long press and idle reports
// req_chan: one item per poll (op, time_ms, count_changed, knob_count, button_level)
// rsp_chan: one item per request (rotation_event, button_event, idle_expired)
// csr_chan: register writes, index 0..4 as gap, debounce, long press, sleep, pressed level;
//    always ready, indexes beyond 4 are ignored; write only while the block is idle
// latency: response valid 1 cycle after the request accept edge, so it can be taken
//    2 edges after the request at the earliest (input register, then the result
//    register loaded together with the knob / button state)
// throughput: one item per cycle; the single state update per item is one cycle of
//    subtract / compare logic, so consecutive items chain through the state registers
// stall: the result register and the input register together let the block take a new
//    item while a finished result waits; req ready drops only when both are full
// reset: synchronous, clears both stages, loads register defaults and the idle state
//    (button released, long press handled, all times zero)
module rotary_button_event_qualifier_top (
   input logic      clock,
   input logic      reset,
   rbeq_req_if.sink   req_chan,
   rbeq_rsp_if.source rsp_chan,
   rbeq_csr_if.sink   csr_chan
);
   import rbeq_pkg::*;

   // configuration registers
   cfg_type    cfg_ff, cfg_in;

   // input stage
   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff, s1_item_in;

   // knob / button state
   state_type  state_ff, state_in, state_nxt;

   // result stage
   logic       s2_valid_ff, s2_valid_in;
   result_type s2_res_ff, s2_res_in, res_nxt;

   logic req_acc;
   logic s2_take;
   logic s1_move;

   assign s2_take = !s2_valid_ff || rsp_chan.ready;
   assign s1_move = s1_valid_ff && s2_take;
   assign req_chan.ready = !s1_valid_ff || s2_take;
   assign req_acc = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_ROTATION_GAP: cfg_in.rotation_gap_ms  = csr_chan.data[CfgWidth-1:0];
            CSR_DEBOUNCE:     cfg_in.debounce_ms      = csr_chan.data[CfgWidth-1:0];
            CSR_LONG_PRESS:   cfg_in.long_press_ms    = csr_chan.data[CfgWidth-1:0];
            CSR_SLEEP:        cfg_in.sleep_timeout_ms = csr_chan.data[TimeWidth-1:0];
            CSR_PRESSED_LVL:  cfg_in.pressed_level    = csr_chan.data[0];
            default: begin
            end
         endcase
      end
   end

   // input stage capture
   always_comb begin
      s1_item_in  = s1_item_ff;
      s1_valid_in = s1_valid_ff;
      if (req_acc) begin
         s1_valid_in              = 1'b1;
         s1_item_in.op            = req_chan.op;
         s1_item_in.time_ms       = req_chan.time_ms;
         s1_item_in.count_changed = req_chan.count_changed;
         s1_item_in.knob_count    = req_chan.knob_count;
         s1_item_in.button_level  = req_chan.button_level;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   rbeq_core u_core (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (s1_item_ff),
      .nxt  (state_nxt),
      .res  (res_nxt)
   );

   // state and result advance together when the item leaves the input stage
   always_comb begin
      state_in    = state_ff;
      s2_res_in   = s2_res_ff;
      s2_valid_in = s2_valid_ff;
      if (s1_move) begin
         state_in    = state_nxt;
         s2_res_in   = res_nxt;
         s2_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotation_gap_ms     <= RotationGapReset;
         cfg_ff.debounce_ms         <= DebounceReset;
         cfg_ff.long_press_ms       <= LongPressReset;
         cfg_ff.sleep_timeout_ms    <= SleepReset;
         cfg_ff.pressed_level       <= PressedLvlReset;
         s1_valid_ff                <= 1'b0;
         s2_valid_ff                <= 1'b0;
         state_ff.ref_count          <= '0;
         state_ff.last_rotation_time <= '0;
         state_ff.stable_level       <= ~PressedLvlReset;
         state_ff.edge_time          <= '0;
         state_ff.press_start        <= '0;
         state_ff.long_done          <= 1'b1;
         state_ff.interaction_time   <= '0;
      end else begin
         cfg_ff      <= cfg_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         state_ff    <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      s2_res_ff  <= s2_res_in;
   end

   assign rsp_chan.valid          = s2_valid_ff;
   assign rsp_chan.rotation_event = s2_res_ff.rotation_event;
   assign rsp_chan.button_event   = s2_res_ff.button_event;
   assign rsp_chan.idle_expired   = s2_res_ff.idle_expired;

endmodule

/* src/rbeq_checker.sv */
// checker: port-level assertions for the event qualifier, bound to the top level
module rbeq_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rotation_event,
   input logic [1:0] button_event,
   input logic       idle_expired
);
   import rbeq_pkg::*;

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rotation_event) && $stable(button_event) &&
          $stable(idle_expired)))
      else $error("stalled response changed");

   // input blocked only when a result is waiting
   a_block_needs_full: assert property (@(posedge clock) disable iff (reset)
      (!req_ready && req_valid) |-> rsp_valid)
      else $error("request blocked with empty response stage");

   // any reported event is an interaction, so idle cannot be flagged with it
   a_event_not_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rotation_event != ROT_NONE || button_event != BTN_NONE)) |->
         !idle_expired)
      else $error("idle flagged together with an event");

endmodule

bind rotary_button_event_qualifier_top rbeq_checker u_rbeq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rotation_event (rsp_chan.rotation_event),
   .button_event   (rsp_chan.button_event),
   .idle_expired   (rsp_chan.idle_expired)
);
